### rtl/hep_pkg.sv
// shared constants, types and request codes of the huffman encoder bit packer
package hep_pkg;

    // code and alphabet limits
    localparam int MAX_CODE_LEN = 16;
    localparam int ALPHABET     = 256;
    localparam int BYTE_BITS    = 8;
    localparam int VALUE_BITS   = 16;
    localparam int LEN_W        = 5;
    localparam int SYM_W        = 8;
    localparam int CODE_LIM     = (MAX_CODE_LEN < VALUE_BITS) ? MAX_CODE_LEN : VALUE_BITS;
    localparam int SYM_AW       = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ENTRY_W      = VALUE_BITS + LEN_W;

    // pending byte holds up to seven bits
    localparam int PEND_W       = BYTE_BITS - 1;
    localparam int CNT_W        = 3;
    localparam int ACC_W        = PEND_W + VALUE_BITS;

    // result queue
    localparam int QDEPTH       = 4;
    localparam int QAW          = $clog2(QDEPTH);
    localparam int QCW          = $clog2(QDEPTH + 1);

    // request codes
    typedef logic [1:0] req_type_t;
    localparam req_type_t REQ_LOAD   = 2'd0;
    localparam req_type_t REQ_ENCODE = 2'd1;
    localparam req_type_t REQ_FLUSH  = 2'd2;

    typedef logic [SYM_W-1:0]      symbol_t;
    typedef logic [VALUE_BITS-1:0] code_value_t;
    typedef logic [LEN_W-1:0]      code_length_t;

    // one result item
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } result_t;

    // control of the lookup stage
    typedef struct packed {
        req_type_t req_type;
        logic      hit;
    } stage_t;

endpackage

### rtl/hep_if.sv
// request and result channel interfaces of the huffman encoder bit packer
interface hep_req_if import hep_pkg::*;;
    logic         valid;
    logic         ready;
    req_type_t    req_type;
    symbol_t      symbol;
    code_value_t  code_value;
    code_length_t code_length;

    modport source (output valid, req_type, symbol, code_value, code_length, input ready);
    modport sink   (input valid, req_type, symbol, code_value, code_length, output ready);
endinterface

interface hep_res_if import hep_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

### rtl/hep_ram.sv
// generic single write port ram with registered read
module hep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/huffman_encoder_bit_packer.sv
// Huffman encoder bit packer: code table, msb-first byte packing and result queue.
// A request item is accepted in every cycle while the lookup stage can move on.
// The symbol's table entry is read from a 256 x 21 ram in the accept cycle and
// held with the request in the lookup stage, which packs it and writes its
// result items into the result queue when it moves on; the queue head is
// offered on the result channel. An encode that completes two bytes, and every
// flush, puts two items into a four-entry result queue; the result channel
// drains one item per cycle while the receiver is ready, so loads and short
// codes are accepted at one request per cycle, while requests that each yield
// two bytes are held back by the queue until it drains. The table needs no
// clearing pass after reset: a valid bit per entry, cleared by reset, makes an
// unwritten entry read as an empty code. Flush emits the padded last byte and
// then the free bit count (1 to 8) marked with last, and starts a new run empty.
module huffman_encoder_bit_packer import hep_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    hep_req_if.sink          req,
    hep_res_if.source        rsp
);

    // accept and table write
    logic                   in_accept;
    logic                   sym_ok;
    code_length_t           len_cl;
    logic [VALUE_BITS:0]    len_mask;
    logic [ENTRY_W-1:0]     wr_entry;
    logic                   tbl_we;
    logic [SYM_AW-1:0]      tbl_addr;
    logic [ENTRY_W-1:0]     tbl_rdata;
    logic [ALPHABET-1:0]    tbl_vld_reg;

    // lookup stage
    logic                   s1_valid_reg;
    stage_t                 s1_reg;
    logic                   s1_fire;

    // packing
    logic [PEND_W-1:0]      pend_bits_reg;
    logic [PEND_W-1:0]      pend_bits_next;
    logic [CNT_W-1:0]       pend_count_reg;
    logic [CNT_W-1:0]       pend_count_next;
    logic [ENTRY_W-1:0]     entry;
    code_length_t           e_len;
    code_value_t            e_val;
    logic [ACC_W-1:0]       acc;
    logic [LEN_W-1:0]       total;
    logic [ACC_W-1:0]       sh0;
    logic [ACC_W-1:0]       sh1;
    logic [PEND_W:0]        cnt_mask;
    logic [PEND_W+BYTE_BITS-1:0] flush_sh;
    logic [3:0]             free_bits;
    logic [1:0]             n_push;
    result_t                r0;
    result_t                r1;

    // result queue
    result_t                q_reg [QDEPTH];
    logic [QAW-1:0]         q_wr_reg;
    logic [QAW-1:0]         q_rd_reg;
    logic [QCW-1:0]         q_count_reg;
    logic                   q_pop;

    // input handshake
    assign s1_fire   = s1_valid_reg && (q_count_reg <= QCW'(QDEPTH - 2));
    assign req.ready = !s1_valid_reg || s1_fire;
    assign in_accept = req.valid && req.ready;

    // load data: clamp length and drop value bits above it
    assign sym_ok   = ({1'b0, req.symbol} < (SYM_W + 1)'(ALPHABET));
    assign len_cl   = (req.code_length > LEN_W'(CODE_LIM)) ? LEN_W'(CODE_LIM) : req.code_length;
    assign len_mask = ((VALUE_BITS + 1)'(1) << len_cl) - (VALUE_BITS + 1)'(1);
    assign wr_entry = {len_cl, req.code_value & len_mask[VALUE_BITS-1:0]};
    assign tbl_we   = in_accept && (req.req_type == REQ_LOAD) && sym_ok;
    assign tbl_addr = req.symbol[SYM_AW-1:0];

    hep_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_addr),
        .wdata (wr_entry),
        .re    (in_accept),
        .raddr (tbl_addr),
        .rdata (tbl_rdata)
    );

    // table entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_vld_reg <= '0;
        end
        else if (tbl_we)
        begin
            tbl_vld_reg[tbl_addr] <= 1'b1;
        end
    end

    // lookup stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.req_type <= req.req_type;
            s1_reg.hit      <= sym_ok && tbl_vld_reg[tbl_addr];
        end
    end

    // append code bits and cut out full bytes
    assign entry     = s1_reg.hit ? tbl_rdata : '0;
    assign e_val     = entry[VALUE_BITS-1:0];
    assign e_len     = entry[ENTRY_W-1:VALUE_BITS];
    assign acc       = (ACC_W'(pend_bits_reg) << e_len) | ACC_W'(e_val);
    assign total     = LEN_W'(pend_count_reg) + e_len;
    assign sh0       = acc >> (total - LEN_W'(BYTE_BITS));
    assign sh1       = acc >> (total - LEN_W'(2 * BYTE_BITS));
    assign cnt_mask  = ((PEND_W + 1)'(1) << total[CNT_W-1:0]) - (PEND_W + 1)'(1);
    assign flush_sh  = {pend_bits_reg, {BYTE_BITS{1'b0}}} >> pend_count_reg;
    assign free_bits = 4'(BYTE_BITS) - {1'b0, pend_count_reg};

    always_comb
    begin
        n_push          = 2'd0;
        r0              = '{out_byte: sh0[BYTE_BITS-1:0], last: 1'b0};
        r1              = '{out_byte: sh1[BYTE_BITS-1:0], last: 1'b0};
        pend_count_next = pend_count_reg;
        pend_bits_next  = pend_bits_reg;
        case (s1_reg.req_type)
            REQ_ENCODE:
            begin
                if (total >= LEN_W'(2 * BYTE_BITS))
                begin
                    n_push = 2'd2;
                end
                else if (total >= LEN_W'(BYTE_BITS))
                begin
                    n_push = 2'd1;
                end
                pend_count_next = total[CNT_W-1:0];
                pend_bits_next  = acc[PEND_W-1:0] & cnt_mask[PEND_W-1:0];
            end
            REQ_FLUSH:
            begin
                n_push          = 2'd2;
                r0              = '{out_byte: flush_sh[BYTE_BITS-1:0], last: 1'b0};
                r1              = '{out_byte: {4'b0, free_bits}, last: 1'b1};
                pend_count_next = '0;
                pend_bits_next  = '0;
            end
            default:
            begin
                n_push = 2'd0;
            end
        endcase
    end

    // pending byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end
        else if (s1_fire)
        begin
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (s1_fire && (n_push != 2'd0))
        begin
            q_reg[q_wr_reg] <= r0;
        end
        if (s1_fire && (n_push == 2'd2))
        begin
            q_reg[q_wr_reg + QAW'(1)] <= r1;
        end
    end

    // result queue pointers
    assign q_pop = rsp.valid && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (s1_fire)
            begin
                q_wr_reg <= q_wr_reg + QAW'(n_push);
            end
            if (q_pop)
            begin
                q_rd_reg <= q_rd_reg + QAW'(1);
            end
            q_count_reg <= q_count_reg + (s1_fire ? QCW'(n_push) : QCW'(0))
                           - (q_pop ? QCW'(1) : QCW'(0));
        end
    end

    // result channel
    assign rsp.valid    = (q_count_reg != '0);
    assign rsp.out_byte = q_reg[q_rd_reg].out_byte;
    assign rsp.last     = q_reg[q_rd_reg].last;

    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= QCW'(QDEPTH))
        else $error("result queue overfilled");

    // lookup stage moves on only with room for two items
    a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> (q_count_reg <= QCW'(QDEPTH - 2)))
        else $error("lookup stage fired without queue room");

    // flush leaves the pending byte empty
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_reg.req_type == REQ_FLUSH)) |=> (pend_count_reg == '0))
        else $error("pending bits left after flush");

    // pending state changes only when the lookup stage fires
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(pend_count_reg) && $stable(pend_bits_reg))
        else $error("pending state changed without an item");

endmodule

### tb/sv/hep_stream_checker.sv
`timescale 1ns / 1ps
// stream checker: predicts the packed byte stream from accepted requests and compares results
module hep_stream_checker import hep_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    hep_req_if   req,
    hep_res_if   rsp,
    output int   errors,
    output int   pending
);

    // one code table entry as the predictor keeps it
    typedef struct packed {
        code_length_t len;
        code_value_t  value;
    } code_entry_t;

    code_entry_t       code_book [ALPHABET];
    logic [PEND_W-1:0] held_bits;
    logic [CNT_W-1:0]  held_count;
    result_t           expected_bytes [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // update the code table or the pending byte and queue the bytes an item causes
    task automatic pack_request(input req_type_t rt, input symbol_t sym,
                                input code_value_t val, input code_length_t len);
        code_entry_t entry;
        logic [31:0] acc;
        int          total;
        int          freeb;
        int          n;
        result_t     res;
        n = 0;
        case (rt)
            REQ_LOAD:
            begin
                // long codes are clamped, bits above the stored length dropped
                if (int'(sym) < ALPHABET)
                begin
                    entry.len   = (int'(len) > CODE_LIM) ? code_length_t'(CODE_LIM) : len;
                    entry.value = val & code_value_t'((32'h1 << entry.len) - 1);
                    code_book[sym] = entry;
                end
            end
            REQ_ENCODE:
            begin
                // symbols past the alphabet act as empty codes
                entry = (int'(sym) < ALPHABET) ? code_book[sym] : '0;
                if (entry.len != '0)
                begin
                    acc   = ({25'd0, held_bits} << entry.len) | 32'(entry.value);
                    total = int'(held_count) + int'(entry.len);
                    while (total >= BYTE_BITS && n < 2)
                    begin
                        res.out_byte = BYTE_BITS'(acc >> (total - BYTE_BITS));
                        res.last     = 1'b0;
                        expected_bytes = {expected_bytes, res};
                        total -= BYTE_BITS;
                        n++;
                    end
                    held_count = CNT_W'(total);
                    held_bits  = PEND_W'(acc & ((32'h1 << total) - 1));
                end
            end
            REQ_FLUSH:
            begin
                // padded last byte, then the free bit count marked last
                freeb        = BYTE_BITS - int'(held_count);
                res.out_byte = BYTE_BITS'({25'd0, held_bits} << freeb);
                res.last     = 1'b0;
                expected_bytes = {expected_bytes, res};
                res.out_byte = BYTE_BITS'(freeb);
                res.last     = 1'b1;
                expected_bytes = {expected_bytes, res};
                held_bits  = '0;
                held_count = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
                code_book[i] = '0;
            held_bits  = '0;
            held_count = '0;
            expected_bytes.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding",
                                    int'({rsp.out_byte, rsp.last}), 0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (rsp.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(rsp.out_byte), int'(want.out_byte));
                    if (rsp.last !== want.last)
                        report_mismatch("last", int'(rsp.last), int'(want.last));
                end
            end
            if (req.valid && req.ready)
                pack_request(req.req_type, req.symbol, req.code_value, req.code_length);
            pending <= expected_bytes.size();
        end
    end

endmodule

### tb/sv/tb_huffman_encoder_bit_packer.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus, result back-pressure and verdict
module tb_huffman_encoder_bit_packer;
    import hep_pkg::*;

    localparam req_type_t REQ_UNUSED     = 2'd3;
    localparam int        RANDOM_ITEMS   = 1400;
    localparam int        WORKING_SET    = 32;
    localparam int        IDLE_PCT       = 15;
    localparam int        WATCHDOG_LIMIT = 2000;
    localparam int        DRAIN_CYCLES   = 16;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   err_count;
    int   pending_results;
    int   idle_cycles;

    hep_req_if req_ch ();
    hep_res_if rsp_ch ();

    huffman_encoder_bit_packer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    hep_stream_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (err_count),
        .pending (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // present one request item and hold it until accepted
    task automatic send_item(input req_type_t rt, input symbol_t sym,
                             input code_value_t val, input code_length_t len);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.symbol      <= sym;
        req_ch.code_value  <= val;
        req_ch.code_length <= len;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // hold off requests until every predicted byte has come out
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // mostly legal lengths, some empty, some over the limit
    function automatic code_length_t rand_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 88)
            return code_length_t'($urandom_range(1, 16));
        else
            return code_length_t'($urandom_range(17, 31));
    endfunction

    // mostly symbols of the loaded working set
    function automatic symbol_t rand_symbol();
        if ($urandom_range(0, 99) < 85)
            return symbol_t'($urandom_range(0, WORKING_SET - 1));
        else
            return symbol_t'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int r;
        rst_n              <= 1'b0;
        no_idle            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_LOAD;
        req_ch.symbol      <= '0;
        req_ch.code_value  <= '0;
        req_ch.code_length <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty flush, clamping, empty codes, byte crossings, padding
        send_item(REQ_FLUSH,  8'd0,   16'h0000, 5'd0);
        send_item(REQ_LOAD,   8'd0,   16'h0001, 5'd1);
        send_item(REQ_LOAD,   8'd255, 16'hFFFF, 5'd16);
        send_item(REQ_LOAD,   8'd128, 16'hAAAA, 5'd31);
        send_item(REQ_LOAD,   8'd1,   16'hFFFF, 5'd3);
        send_item(REQ_LOAD,   8'd2,   16'h1234, 5'd0);
        send_item(REQ_ENCODE, 8'd2,   16'h0000, 5'd0);
        send_item(REQ_ENCODE, 8'd3,   16'hFFFF, 5'd31);
        send_item(REQ_ENCODE, 8'd0,   16'h0000, 5'd0);
        send_item(REQ_ENCODE, 8'd255, 16'h0000, 5'd0);
        send_item(REQ_ENCODE, 8'd128, 16'h0000, 5'd0);
        send_item(REQ_UNUSED, 8'd0,   16'hFFFF, 5'd16);
        send_item(REQ_ENCODE, 8'd1,   16'h0000, 5'd0);
        send_item(REQ_FLUSH,  8'd0,   16'h0000, 5'd0);
        send_item(REQ_ENCODE, 8'd1,   16'h0000, 5'd0);
        send_item(REQ_ENCODE, 8'd1,   16'h0000, 5'd0);
        send_item(REQ_ENCODE, 8'd0,   16'h0000, 5'd0);
        send_item(REQ_FLUSH,  8'd0,   16'h0000, 5'd0);
        send_item(REQ_LOAD,   8'd255, 16'h0000, 5'd17);
        send_item(REQ_ENCODE, 8'd255, 16'h0000, 5'd0);
        send_item(REQ_FLUSH,  8'd0,   16'h0000, 5'd0);
        wait_drained();

        // fill the working set, then random traffic over it
        for (int s = 0; s < WORKING_SET; s++)
            send_item(REQ_LOAD, symbol_t'(s), code_value_t'($urandom_range(0, 65535)),
                      rand_length());
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle <= (i >= 500 && i < 750);
            if (i == 900)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 12)
                send_item(REQ_LOAD, rand_symbol(), code_value_t'($urandom_range(0, 65535)),
                          rand_length());
            else if (r < 84)
                send_item(REQ_ENCODE, rand_symbol(), code_value_t'($urandom_range(0, 65535)),
                          code_length_t'($urandom_range(0, 31)));
            else if (r < 94)
                send_item(REQ_FLUSH, symbol_t'($urandom_range(0, 255)),
                          code_value_t'($urandom_range(0, 65535)),
                          code_length_t'($urandom_range(0, 31)));
            else
                send_item(REQ_UNUSED, symbol_t'($urandom_range(0, 255)),
                          code_value_t'($urandom_range(0, 65535)),
                          code_length_t'($urandom_range(0, 31)));
        end

        // drain, then watch for stray results
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
